// File: hdl/ilbd_pkg.sv
// shared types, constants and codes of the isax lower-bound distance block
package ilbd_pkg;

   // parameter defaults
   localparam int DEF_MAX_SEGMENTS = 16;
   localparam int DEF_SYMBOL_BITS  = 8;
   localparam int DEF_VALUE_WIDTH  = 32;

   // fixed field widths
   localparam int SEG_WIDTH    = 4;
   localparam int BITS_WIDTH   = 4;
   localparam int SYMBOL_WIDTH = 8;
   localparam int SLOT_WIDTH   = 9;
   localparam int VALUE_PORT   = 32;
   localparam int DIST_WIDTH   = 63;

   // breakpoint store layout: segment, level code, slot
   localparam int LEVEL_WIDTH = 3;
   localparam int ADDR_WIDTH  = SEG_WIDTH + LEVEL_WIDTH + SLOT_WIDTH;
   localparam int STORE_DEPTH = 1 << ADDR_WIDTH;

   // accumulator and scaling
   localparam int SUM_WIDTH    = 64;
   localparam int HALF_WIDTH   = SUM_WIDTH / 2;
   localparam int SCALE_WIDTH  = 32;
   localparam int PROD_WIDTH   = HALF_WIDTH + SCALE_WIDTH;
   localparam int SCALE_SHIFT  = 16;
   localparam int PH_LIMIT_BIT = DIST_WIDTH - SCALE_SHIFT;
   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 32'h0001_0000;

   // request opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ACCUM = 1'b1;

   typedef struct packed {
      logic                           opcode;
      logic [SEG_WIDTH-1:0]           segment;
      logic [BITS_WIDTH-1:0]          bits;
      logic [SYMBOL_WIDTH-1:0]        symbol;
      logic [SLOT_WIDTH-1:0]          slot;
      logic signed [VALUE_PORT-1:0]   value;
      logic                           last;
   } req_type;

   typedef struct packed {
      logic [DIST_WIDTH-1:0] distance;
      logic                  saturated;
   } rsp_type;

   // per-state strobes from the sequencer to the arithmetic
   typedef struct packed {
      logic cmp_en;
      logic sq_en;
      logic acc_en;
      logic mul_hi;
      logic mul_lo;
      logic clear;
   } ctrl_type;

endpackage

// File: hdl/ilbd_ram.sv
// generic single-write, single-read ram with registered read data
module ilbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ilbd_store.sv
// breakpoint store: address generation and two mirrored rams for floor and ceiling reads
module ilbd_store
   import ilbd_pkg::*;
#(
   parameter int SYMBOL_BITS = DEF_SYMBOL_BITS,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  req_type                req,
   input  logic                   wr_en,
   input  logic                   rd_en,
   output logic [VALUE_WIDTH-1:0] rd_lo,
   output logic [VALUE_WIDTH-1:0] rd_hi
);

   localparam logic [BITS_WIDTH-1:0]   SymBitsCode = BITS_WIDTH'(SYMBOL_BITS);
   localparam logic [SYMBOL_WIDTH-1:0] SymMask     = SYMBOL_WIDTH'((1 << SYMBOL_BITS) - 1);

   logic [BITS_WIDTH-1:0]   level;
   logic [BITS_WIDTH-1:0]   shift;
   logic [SYMBOL_WIDTH-1:0] sym;
   logic [SLOT_WIDTH-1:0]   idx_lo;
   logic [SLOT_WIDTH-1:0]   idx_hi;
   logic [ADDR_WIDTH-1:0]   wr_addr;
   logic [ADDR_WIDTH-1:0]   addr_lo;
   logic [ADDR_WIDTH-1:0]   addr_hi;

   // level clamped to 1..SYMBOL_BITS
   always_comb begin
      if (req.bits == '0) begin
         level = BITS_WIDTH'(1);
      end else if (req.bits > SymBitsCode) begin
         level = SymBitsCode;
      end else begin
         level = req.bits;
      end
   end

   assign shift  = SymBitsCode - level;
   assign sym    = req.symbol & SymMask;
   assign idx_lo = SLOT_WIDTH'(sym >> shift);
   assign idx_hi = idx_lo + SLOT_WIDTH'(1);

   // level 8 wraps to code 0
   assign wr_addr = {req.segment, level[LEVEL_WIDTH-1:0], req.slot};
   assign addr_lo = {req.segment, level[LEVEL_WIDTH-1:0], idx_lo};
   assign addr_hi = {req.segment, level[LEVEL_WIDTH-1:0], idx_hi};

   ilbd_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_ram_lo (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req.value[VALUE_WIDTH-1:0]),
      .rd_en   (rd_en),
      .rd_addr (addr_lo),
      .rd_data (rd_lo)
   );

   ilbd_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_ram_hi (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req.value[VALUE_WIDTH-1:0]),
      .rd_en   (rd_en),
      .rd_addr (addr_hi),
      .rd_data (rd_hi)
   );

endmodule

// File: hdl/ilbd_math.sv
// distance term, saturating accumulator and split scaling multiply
module ilbd_math
   import ilbd_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_type               ctrl,
   input  logic [VALUE_WIDTH-1:0] v,
   input  logic                   seg_ok,
   input  logic [VALUE_WIDTH-1:0] bp_lo,
   input  logic [VALUE_WIDTH-1:0] bp_hi,
   input  logic [SCALE_WIDTH-1:0] scale,
   output rsp_type                result
);

   localparam int SqWidth = 2 * VALUE_WIDTH;

   logic [VALUE_WIDTH:0]    d_lo;
   logic [VALUE_WIDTH:0]    d_hi;
   logic                    lt;
   logic                    gt;
   logic [VALUE_WIDTH-1:0]  mag_in,  mag_ff;
   logic                    term_in, term_ff;
   logic [SqWidth-1:0]      sq_in,   sq_ff;
   logic [SUM_WIDTH:0]      sum_wide;
   logic [SUM_WIDTH-1:0]    sum_in,  sum_ff;
   logic                    ovf_in,  ovf_ff;
   logic [HALF_WIDTH-1:0]   mul_a;
   logic [PROD_WIDTH-1:0]   mul_prod;
   logic [PROD_WIDTH-1:0]   ph_ff;
   logic [PROD_WIDTH-1:0]   pl_ff;
   logic [SUM_WIDTH-1:0]    r_sum;
   logic                    mul_sat;

   // floor / ceiling test, exact difference
   assign lt   = $signed(v) < $signed(bp_lo);
   assign gt   = $signed(v) > $signed(bp_hi);
   assign d_lo = {bp_lo[VALUE_WIDTH-1], bp_lo} - {v[VALUE_WIDTH-1], v};
   assign d_hi = {v[VALUE_WIDTH-1], v} - {bp_hi[VALUE_WIDTH-1], bp_hi};

   assign mag_in  = lt ? d_lo[VALUE_WIDTH-1:0] : d_hi[VALUE_WIDTH-1:0];
   assign term_in = seg_ok && (lt || gt);
   assign sq_in   = term_ff ? (SqWidth'(mag_ff) * SqWidth'(mag_ff)) : '0;

   // saturating add of the squared term
   assign sum_wide = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(sq_ff);

   always_comb begin
      sum_in = sum_ff;
      ovf_in = ovf_ff;
      if (ctrl.clear) begin
         sum_in = '0;
         ovf_in = 1'b0;
      end else if (ctrl.acc_en) begin
         if (sum_wide[SUM_WIDTH]) begin
            sum_in = '1;
            ovf_in = 1'b1;
         end else begin
            sum_in = sum_wide[SUM_WIDTH-1:0];
         end
      end
   end

   // one 32x32 multiplier, upper half then lower half of the sum
   assign mul_a    = ctrl.mul_hi ? sum_ff[SUM_WIDTH-1:HALF_WIDTH] : sum_ff[HALF_WIDTH-1:0];
   assign mul_prod = PROD_WIDTH'(mul_a) * PROD_WIDTH'(scale);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.cmp_en) begin
         mag_ff  <= mag_in;
         term_ff <= term_in;
      end
      if (ctrl.sq_en) begin
         sq_ff <= sq_in;
      end
      if (ctrl.mul_hi) begin
         ph_ff <= mul_prod;
      end
      if (ctrl.mul_lo) begin
         pl_ff <= mul_prod;
      end
   end

   // (sum * scale) >> 16 from the two partial products
   assign r_sum   = (ph_ff << SCALE_SHIFT) + (pl_ff >> SCALE_SHIFT);
   assign mul_sat = (|ph_ff[PROD_WIDTH-1:PH_LIMIT_BIT]) || r_sum[SUM_WIDTH-1];

   assign result.distance  = mul_sat ? '1 : r_sum[DIST_WIDTH-1:0];
   assign result.saturated = mul_sat || ovf_ff;

   a_clear_empties_sum: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (sum_ff == '0) && !ovf_ff)
      else $error("accumulator not cleared after result");

endmodule

// File: hdl/isax_lower_bound_distance.sv
// top level of the isax lower-bound distance block: sequencer, config register, response register
//
//  channel   direction  handshake                 payload
//  req_      in         req_valid / req_stall     req_payload (req_type)
//  rsp_      out        rsp_valid / rsp_stall     rsp_payload (rsp_type)
//  csr_      in         csr_wr_en                 csr_wr_data (scale factor)
//
//  a load request writes its breakpoint to both store rams at acceptance, if its segment is in range
//  an accumulate request steps through ram read, compare, square, accumulate
//  a last-segment request goes on to two halves of the scaling multiply, then result
//  the shared multiplier and the read-modify-write of the sum set one request at a time
//  sync active-high reset clears sequencer, sum, flag and response valid; store is not cleared
//  a stalled response holds the result stage only while a result is already waiting
module isax_lower_bound_distance
   import ilbd_pkg::*;
#(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
   parameter int SYMBOL_BITS  = DEF_SYMBOL_BITS,
   parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   // scale factor register
   input  logic                   csr_wr_en,
   input  logic [SCALE_WIDTH-1:0] csr_wr_data
);

   localparam logic [SEG_WIDTH:0] SegLimit = (SEG_WIDTH + 1)'(MAX_SEGMENTS);

   // one-hot sequencer states
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_CMP  = 7'b0000010,
      ST_SQ   = 7'b0000100,
      ST_ACC  = 7'b0001000,
      ST_HI   = 7'b0010000,
      ST_LO   = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   logic [SCALE_WIDTH-1:0]   scale_ff;
   logic [VALUE_WIDTH-1:0]   v_ff;
   logic                     seg_ok_ff;
   logic                     last_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_payload_ff;

   logic                     req_take;
   logic                     seg_ok;
   logic                     st_wr_en;
   logic                     st_rd_en;
   logic                     out_free;
   logic                     out_load;
   logic [VALUE_WIDTH-1:0]   bp_lo;
   logic [VALUE_WIDTH-1:0]   bp_hi;
   ctrl_type                 ctrl;
   rsp_type                  result;

   // request handshake: only idle takes a new request
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // segments past the configured count are ignored
   assign seg_ok   = ({1'b0, req_payload.segment} < SegLimit);
   assign st_wr_en = req_take && (req_payload.opcode == OP_LOAD) && seg_ok;
   assign st_rd_en = req_take && (req_payload.opcode == OP_ACCUM);

   // response slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == ST_FIN) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (st_rd_en) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_SQ;
         end
         ST_SQ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = last_ff ? ST_HI : ST_IDLE;
         end
         ST_HI: begin
            state_in = ST_LO;
         end
         ST_LO: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // strobes to the arithmetic
   assign ctrl.cmp_en = (state_ff == ST_CMP);
   assign ctrl.sq_en  = (state_ff == ST_SQ);
   assign ctrl.acc_en = (state_ff == ST_ACC);
   assign ctrl.mul_hi = (state_ff == ST_HI);
   assign ctrl.mul_lo = (state_ff == ST_LO);
   assign ctrl.clear  = out_load;

   // response valid: set on a new result, dropped once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         scale_ff     <= SCALE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            scale_ff <= csr_wr_data;
         end
      end
   end

   // request fields held for the duration of an accumulate
   always_ff @(posedge clock) begin
      if (st_rd_en) begin
         v_ff      <= req_payload.value[VALUE_WIDTH-1:0];
         seg_ok_ff <= seg_ok;
         last_ff   <= req_payload.last;
      end
      if (out_load) begin
         rsp_payload_ff <= result;
      end
   end

   ilbd_store #(
      .SYMBOL_BITS (SYMBOL_BITS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock (clock),
      .req   (req_payload),
      .wr_en (st_wr_en),
      .rd_en (st_rd_en),
      .rd_lo (bp_lo),
      .rd_hi (bp_hi)
   );

   ilbd_math #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_math (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .v      (v_ff),
      .seg_ok (seg_ok_ff),
      .bp_lo  (bp_lo),
      .bp_hi  (bp_hi),
      .scale  (scale_ff),
      .result (result)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_load_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_payload.opcode == OP_LOAD)) |=> (state_ff == ST_IDLE))
      else $error("load request left the sequencer busy");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      st_wr_en |-> (state_ff == ST_IDLE))
      else $error("store written while an accumulate is in flight");

   a_mid_word_returns: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ACC) && !last_ff) |=> (state_ff == ST_IDLE) && !ctrl.clear)
      else $error("non-last segment did not return to idle");

   a_result_presented: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("finished result not presented");

endmodule
